// ----- rtl/iirb_pkg.sv -----
`default_nettype none

package iirb_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 24;
	localparam int FRAC_W        = 20;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W         = PROD_W + 4;
	localparam int RND_W         = ACC_W - FRAC_W;
	localparam int REG_IDX_W     = 3;
	localparam int DEFAULT_ORDER = 2;

	localparam logic [REG_IDX_W-1:0] REG_A0         = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_A1         = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_A2         = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_B1         = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_B2         = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIX_ENABLE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MIX_GAIN   = 3'd6;

	localparam logic signed [COEF_W-1:0] A0_RESET   = 24'sd1048576;
	localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);
	localparam logic signed [RND_W-1:0]  SAT_MAX    = RND_W'(32767);
	localparam logic signed [RND_W-1:0]  SAT_MIN    = RND_W'(-32768);

	typedef enum logic [2:0] {
		OP_A0,
		OP_A1,
		OP_B1,
		OP_A2,
		OP_B2,
		OP_MIX
	} op_sel_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] mix_gain;
		logic                     mix_enable;
	} coef_t;

	typedef struct packed {
		logic    load_x;
		logic    mul_en;
		op_sel_t op;
		logic    acc_add;
		logic    fin_filter;
		logic    mix_init;
		logic    fin_mix;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic mix_enable;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       clip;
	} rsat_t;

	function automatic rsat_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [RND_W-1:0] r;
		rsat_t                   res;
		biased    = acc + ROUND_BIAS;
		r         = biased[ACC_W-1:FRAC_W];
		res.value = r[SAMPLE_W-1:0];
		res.clip  = 1'b0;
		if (r > SAT_MAX) begin
			res.value = SAT_MAX[SAMPLE_W-1:0];
			res.clip  = 1'b1;
		end else if (r < SAT_MIN) begin
			res.value = SAT_MIN[SAMPLE_W-1:0];
			res.clip  = 1'b1;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/iirb_regs.sv -----
`default_nettype none

module iirb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [iirb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [iirb_pkg::COEF_W-1:0]     cfg_data,
	output iirb_pkg::coef_t                      coef
);
	import iirb_pkg::*;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0         <= A0_RESET;
			coef_q.a1         <= '0;
			coef_q.a2         <= '0;
			coef_q.b1         <= '0;
			coef_q.b2         <= '0;
			coef_q.mix_gain   <= '0;
			coef_q.mix_enable <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A0:         coef_q.a0         <= cfg_data;
				REG_A1:         coef_q.a1         <= cfg_data;
				REG_A2:         coef_q.a2         <= cfg_data;
				REG_B1:         coef_q.b1         <= cfg_data;
				REG_B2:         coef_q.b2         <= cfg_data;
				REG_MIX_ENABLE: coef_q.mix_enable <= cfg_data[0];
				REG_MIX_GAIN:   coef_q.mix_gain   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

// ----- rtl/iirb_ctrl.sv -----
`default_nettype none

module iirb_ctrl #(
	parameter int ORDER = iirb_pkg::DEFAULT_ORDER
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire iirb_pkg::stat_t stat,
	output iirb_pkg::cmd_t       cmd
);
	import iirb_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MAC   = 8'b0000_0010,
		ST_DRAIN = 8'b0000_0100,
		ST_ROUND = 8'b0000_1000,
		ST_MIXM  = 8'b0001_0000,
		ST_MIXA  = 8'b0010_0000,
		ST_MIXR  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	localparam op_sel_t LAST_OP = (ORDER > 1) ? OP_B2 : OP_B1;

	state_t  state_q, state_d;
	op_sel_t term_q;
	logic    accept;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.op   = OP_A0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.load_x = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mul_en  = 1'b1;
				cmd.op      = term_q;
				cmd.acc_add = (term_q != OP_A0);
				if (term_q == LAST_OP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.fin_filter = 1'b1;
				state_d        = stat.mix_enable ? ST_MIXM : ST_OUT;
			end
			ST_MIXM: begin
				cmd.mul_en   = 1'b1;
				cmd.op       = OP_MIX;
				cmd.mix_init = 1'b1;
				state_d      = ST_MIXA;
			end
			ST_MIXA: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_MIXR;
			end
			ST_MIXR: begin
				cmd.fin_mix = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= OP_A0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				term_q <= OP_A0;
			end else if (state_q == ST_MAC) begin
				term_q <= op_sel_t'(term_q + 3'd1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iirb_dp.sv -----
`default_nettype none

module iirb_dp #(
	parameter int ORDER = iirb_pkg::DEFAULT_ORDER
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [iirb_pkg::SAMPLE_W-1:0]  s_tdata,
	input  wire iirb_pkg::cmd_t                 cmd,
	input  wire iirb_pkg::coef_t                coef,
	output iirb_pkg::stat_t                     stat,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [iirb_pkg::SAMPLE_W-1:0]       m_tdata,
	output logic                                m_tuser
);
	import iirb_pkg::*;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] x_hist_q [ORDER];
	logic signed [SAMPLE_W-1:0] y_hist_q [ORDER];
	logic signed [SAMPLE_W-1:0] yf_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       sat_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [COEF_W-1:0]   coef_sel;
	logic signed [SAMPLE_W-1:0] data_sel;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_sat_q;
	rsat_t                      rs;

	assign rs = round_sat(acc_q);

	always_comb begin
		case (cmd.op)
			OP_A0: begin
				coef_sel = coef.a0;
				data_sel = x_q;
			end
			OP_A1: begin
				coef_sel = coef.a1;
				data_sel = x_hist_q[0];
			end
			OP_B1: begin
				coef_sel = coef.b1;
				data_sel = y_hist_q[0];
			end
			OP_A2: begin
				coef_sel = coef.a2;
				data_sel = x_hist_q[ORDER-1];
			end
			OP_B2: begin
				coef_sel = coef.b2;
				data_sel = y_hist_q[ORDER-1];
			end
			OP_MIX: begin
				coef_sel = coef.mix_gain;
				data_sel = yf_q;
			end
			default: begin
				coef_sel = '0;
				data_sel = '0;
			end
		endcase
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= s_tdata;
		end
		if (cmd.mul_en) begin
			prod_s1 <= coef_sel * data_sel;
		end
		if (cmd.load_x) begin
			acc_q <= '0;
		end else if (cmd.mix_init) begin
			acc_q <= {{(ACC_W-SAMPLE_W-FRAC_W){x_q[SAMPLE_W-1]}}, x_q, {FRAC_W{1'b0}}};
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.fin_filter) begin
			yf_q  <= rs.value;
			res_q <= rs.value;
			sat_q <= rs.clip;
		end else if (cmd.fin_mix) begin
			res_q <= rs.value;
			sat_q <= sat_q | rs.clip;
		end
		if (cmd.out_load) begin
			out_data_q <= res_q;
			out_sat_q  <= sat_q;
		end
	end

	// filter histories, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else if (cmd.fin_filter) begin
			for (int i = ORDER - 1; i > 0; i--) begin
				x_hist_q[i] <= x_hist_q[i-1];
				y_hist_q[i] <= y_hist_q[i-1];
			end
			x_hist_q[0] <= x_q;
			y_hist_q[0] <= rs.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mix_enable = coef.mix_enable;
	assign stat.out_busy   = out_valid_q && !m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;
	assign m_tuser         = out_sat_q;

endmodule

`default_nettype wire

// ----- rtl/iir_biquad_direct_form_one_core.sv -----
// a result beat is offered once the input beat has passed the MAC, DRAIN, ROUND and OUT states,
// in mix mode with MIXM, MIXA and MIXR before OUT; no new sample is taken before the last result is
// loaded into the output register, as every term uses the single shared 24x16 multiplier, one product per cycle
// a new input beat is taken while the previous result still waits on the output register
// reset: histories cleared, coefficients to their defaults (a0 = 1.0), no result pending
`default_nettype none

module iir_biquad_direct_form_one_core #(
	parameter int ORDER = iirb_pkg::DEFAULT_ORDER
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [iirb_pkg::SAMPLE_W-1:0]   s_tdata,  // [15:0] sample_in
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [iirb_pkg::SAMPLE_W-1:0]        m_tdata,  // [15:0] sample_out
	output logic                                 m_tuser,  // [0] saturated
	input  wire logic                            cfg_we,
	input  wire logic [iirb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [iirb_pkg::COEF_W-1:0]     cfg_data
);
	import iirb_pkg::*;

	coef_t coef;
	cmd_t  cmd;
	stat_t stat;

	iirb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	iirb_ctrl #(
		.ORDER (ORDER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iirb_dp #(
		.ORDER (ORDER)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.coef     (coef),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- verif/biquad_response_check.sv -----
`timescale 1ns / 100ps

module biquad_response_check #(
	parameter int ORDER = iirb_pkg::DEFAULT_ORDER
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [iirb_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [iirb_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
	input  wire logic                           m_tuser,   // [0] saturated
	input  wire logic                           cfg_we,
	input  wire logic [iirb_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [iirb_pkg::COEF_W-1:0]    cfg_data,
	output int                                  outstanding,
	output int                                  mismatches,
	output int                                  samples_seen,
	output int                                  results_seen,
	output int                                  clipped_seen,
	output int                                  mixed_seen
);
	import iirb_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level;
		logic                clip;
	} filtered_t;

	filtered_t expected_out[$];

	logic signed [COEF_W-1:0]   gain_x0, gain_x1, gain_x2, gain_y1, gain_y2, gain_mix;
	logic                       mix_on;
	logic signed [SAMPLE_W-1:0] past_x[2];
	logic signed [SAMPLE_W-1:0] past_y[2];

	task automatic report(input string msg);
		mismatches++;
		$display("%0t ns  mismatch: %s", $time, msg);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] round_clamp(input longint acc,
		output logic hit);
		longint r;
		r   = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		hit = 1'b0;
		if (r > 32767) begin
			hit = 1'b1;
			r   = 32767;
		end else if (r < -32768) begin
			hit = 1'b1;
			r   = -32768;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	task automatic run_filter(input logic signed [SAMPLE_W-1:0] x, output filtered_t res);
		longint                     acc;
		logic signed [SAMPLE_W-1:0] yf;
		logic signed [SAMPLE_W-1:0] ymix;
		logic                       hit_f;
		logic                       hit_m;
		acc = longint'(gain_x0) * longint'(x)
			+ longint'(gain_x1) * longint'(past_x[0])
			+ longint'(gain_y1) * longint'(past_y[0]);
		if (ORDER >= 2)
			acc += longint'(gain_x2) * longint'(past_x[1])
				+ longint'(gain_y2) * longint'(past_y[1]);
		yf = round_clamp(acc, hit_f);
		if (ORDER >= 2) begin
			past_x[1] = past_x[0];
			past_y[1] = past_y[0];
		end
		past_x[0] = x;
		past_y[0] = yf;
		res.level = yf;
		res.clip  = hit_f;
		// mix path: history keeps the plain filter output
		if (mix_on) begin
			acc       = (longint'(x) <<< FRAC_W) + longint'(gain_mix) * longint'(yf);
			ymix      = round_clamp(acc, hit_m);
			res.level = ymix;
			res.clip  = hit_f | hit_m;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		filtered_t want;
		if (!arst_n) begin
			gain_x0   = A0_RESET;
			gain_x1   = '0;
			gain_x2   = '0;
			gain_y1   = '0;
			gain_y2   = '0;
			gain_mix  = '0;
			mix_on    = 1'b0;
			past_x[0] = '0;
			past_x[1] = '0;
			past_y[0] = '0;
			past_y[1] = '0;
			expected_out.delete();
			mismatches   = 0;
			samples_seen = 0;
			results_seen = 0;
			clipped_seen = 0;
			mixed_seen   = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_A0:         gain_x0  = cfg_data;
					REG_A1:         gain_x1  = cfg_data;
					REG_A2:         gain_x2  = cfg_data;
					REG_B1:         gain_y1  = cfg_data;
					REG_B2:         gain_y2  = cfg_data;
					REG_MIX_ENABLE: mix_on   = cfg_data[0];
					REG_MIX_GAIN:   gain_mix = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					report($sformatf("result %0d (%h) with no sample outstanding",
						results_seen, m_tdata));
				end else begin
					want = expected_out.pop_front();
					if (m_tdata !== want.level)
						report($sformatf("result %0d: sample_out %0d, expected %0d",
							results_seen, $signed(m_tdata), $signed(want.level)));
					if (m_tuser !== want.clip)
						report($sformatf("result %0d: saturated %b, expected %b",
							results_seen, m_tuser, want.clip));
				end
			end
			if (s_tvalid && s_tready) begin
				run_filter(s_tdata, want);
				expected_out.push_back(want);
				samples_seen++;
				clipped_seen += want.clip;
				mixed_seen   += mix_on;
			end
			outstanding <= expected_out.size();
		end
	end

endmodule

// ----- verif/iir_biquad_direct_form_one_core_test.sv -----
`timescale 1ns / 100ps

module iir_biquad_direct_form_one_core_test;
	import iirb_pkg::*;

	localparam int                   ORDER       = DEFAULT_ORDER;
	localparam int                   CYCLE_LIMIT = 400000;
	localparam logic [REG_IDX_W-1:0] REG_SPARE   = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [SAMPLE_W-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	int outstanding;
	int mismatches;
	int samples_seen;
	int results_seen;
	int clipped_seen;
	int mixed_seen;
	int filter_sets;
	int cycles;

	iir_biquad_direct_form_one_core #(.ORDER(ORDER)) DUT (.*);

	biquad_response_check #(.ORDER(ORDER)) filter_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] x);
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	task automatic load_filter(input logic [COEF_W-1:0] a0, a1, a2, b1, b2, mix_word, gain,
		input bit spare);
		write_reg(REG_A0, a0);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_MIX_ENABLE, mix_word);
		write_reg(REG_MIX_GAIN, gain);
		if (spare)
			write_reg(REG_SPARE, COEF_W'($urandom()));
		cfg_we <= 1'b0;
		filter_sets++;
	endtask

	function automatic logic [COEF_W-1:0] coef_within(input int mag);
		return COEF_W'($urandom_range(0, 2 * mag) - mag);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return SAMPLE_W'($urandom());
			5, 6, 7:       return SAMPLE_W'($urandom_range(0, 4000) - 2000);
			8:             return 16'h7FFF;
			default:       return $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
		endcase
	endfunction

	task automatic randomise_filter(input int p);
		logic [COEF_W-1:0] c[5];
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] mix_word;
		int                k;
		case (p % 4)
			0: begin
				for (k = 0; k < 5; k++)
					c[k] = COEF_W'($urandom());
			end
			1: begin
				// roughly stable biquad
				c[0] = coef_within(1 << 19);
				c[1] = coef_within(1 << 19);
				c[2] = coef_within(1 << 19);
				c[3] = coef_within(943718);
				c[4] = coef_within(419430);
			end
			2: begin
				for (k = 0; k < 5; k++)
					case ($urandom_range(0, 2))
						0:       c[k] = 24'h7FFFFF;
						1:       c[k] = 24'h800000;
						default: c[k] = '0;
					endcase
			end
			default: begin
				c[0] = 24'h100000 + coef_within(1 << 16);
				for (k = 1; k < 5; k++)
					c[k] = coef_within(1 << 16);
			end
		endcase
		gain     = (p % 3 == 0) ? COEF_W'($urandom()) : coef_within(1 << 20);
		mix_word = (COEF_W'($urandom()) & ~COEF_W'(1)) | COEF_W'(((p >> 2) ^ p) & 1);
		load_filter(c[0], c[1], c[2], c[3], c[4], mix_word, gain, $urandom_range(0, 1));
	endtask

	task automatic stream_random(input int count);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst) send_sample(pick_sample());
			left -= burst;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 15) == 0) begin
				drain();
			end else if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: stretches of full, partial and sparse acceptance, with long hold-offs
	initial begin : sink
		int seg;
		int run;
		int pct;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		seg = 0;
		forever begin
			seg++;
			if (seg % 25 == 3) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
			end else begin
				run = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0:       pct = 100;
					1:       pct = 70;
					default: pct = 30;
				endcase
				repeat (run) begin
					m_tready <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out with %0d results outstanding", outstanding);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int p;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		filter_sets = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients pass samples straight through
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		drain();

		// extreme gains drive both clamps, spare index write ignored
		load_filter(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000,
			24'h000000, 1'b1);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h0000);
		drain();

		// mix on through a wide enable word, largest mix gain
		load_filter(24'h100000, 24'h080000, 24'h000000, 24'h0C0000, 24'hF00000, 24'hABCDE1,
			24'h7FFFFF, 1'b0);
		send_sample(16'd1000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'hFFFF);
		drain();

		// mix on, most negative mix gain
		load_filter(24'h7FFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000001,
			24'h800000, 1'b0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		drain();

		// wide enable word with low bit clear turns mix off
		load_filter(24'h100000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'hFFFFFE,
			24'h800000, 1'b0);
		send_sample(16'h0123);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		drain();

		for (p = 0; p < 8; p++) begin
			randomise_filter(p);
			stream_random(100);
			drain();
		end

		repeat (30) @(posedge clk);
		$display("covered %0d samples and %0d results over %0d filter settings at order %0d",
			samples_seen, results_seen, filter_sets, ORDER);
		$display("%0d results saturated, %0d went through the mix path",
			clipped_seen, mixed_seen);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- iir_biquad_direct_form_one_core.f -----
rtl/iirb_pkg.sv
rtl/iirb_regs.sv
rtl/iirb_ctrl.sv
rtl/iirb_dp.sv
rtl/iir_biquad_direct_form_one_core.sv
verif/biquad_response_check.sv
verif/iir_biquad_direct_form_one_core_test.sv
